@@ hdl/smfc_pkg.sv @@
// ----------------------------------------------------------------------------
// smfc_pkg: shared types and constants of the soil moisture filter
// Widths, gains, queue entry layout and the back end state encoding.
// ----------------------------------------------------------------------------
package smfc_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int IDX_W       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  localparam int SENSOR_W    = 4;
  localparam int SAMPLE_W    = 12;
  localparam int LEVEL_W     = 20;
  localparam int FRAC_W      = 8;
  localparam int PCT_W       = 7;

  localparam int CAL_COUNT   = 8;
  localparam int CAL_SEL_W   = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int CAL_W       = 24;
  localparam int CAL_HALF_W  = 12;

  localparam int GAIN_NEW    = 205;
  localparam int GAIN_OLD    = 51;
  localparam int ROUND_HALF  = 128;
  localparam int PCT_MAX     = 100;

  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int NUM_W       = 19;
  localparam int QUOT_W      = 7;
  localparam int STEP_W      = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                bad;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] raw;
  } smfc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } smfc_q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } smfc_state_t;

endpackage

@@ hdl/smfc_if.sv @@
// ----------------------------------------------------------------------------
// smfc_if: channel interfaces of the soil moisture filter
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface smfc_in_if;
  logic                           valid;
  logic                           ready;
  logic [smfc_pkg::SENSOR_W-1:0]  sensor_number;
  logic [smfc_pkg::SAMPLE_W-1:0]  raw_sample;

  modport source (output valid, output sensor_number, output raw_sample, input ready);
  modport sink   (input valid, input sensor_number, input raw_sample, output ready);
endinterface

interface smfc_out_if;
  logic                           valid;
  logic                           ready;
  logic [smfc_pkg::PCT_W-1:0]     moisture_percent;
  logic [smfc_pkg::SAMPLE_W-1:0]  smoothed_level;
  logic                           error;

  modport source (output valid, output moisture_percent, output smoothed_level,
                  output error, input ready);
  modport sink   (input valid, input moisture_percent, input smoothed_level,
                  input error, output ready);
endinterface

@@ hdl/smfc_front.sv @@
// ----------------------------------------------------------------------------
// smfc_front: sample intake
// Accepts sample beats while the queue has room and tags each one with its
// zero-based sensor slot or as a bad sensor number.
// ----------------------------------------------------------------------------
module smfc_front (
  smfc_in_if.sink                   sample,
  input  smfc_pkg::smfc_q_status_t  status,
  output logic                      push,
  output smfc_pkg::smfc_item_t      item
);
  import smfc_pkg::*;

  logic in_range;

  assign in_range = (sample.sensor_number != '0) &&
                    (sample.sensor_number <= SENSOR_W'(SENSOR_COUNT));

  assign sample.ready = !status.full;
  assign push         = sample.valid && !status.full;

  always_comb begin
    item.bad = !in_range;
    item.idx = IDX_W'(sample.sensor_number - SENSOR_W'(1));
    item.raw = sample.raw_sample;
  end

endmodule

@@ hdl/smfc_queue.sv @@
// ----------------------------------------------------------------------------
// smfc_queue: short queue between intake and processing
// A small circular buffer of classified samples.
// ----------------------------------------------------------------------------
module smfc_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  smfc_pkg::smfc_item_t      push_item,
  input  logic                      pop,
  output smfc_pkg::smfc_item_t      head,
  output smfc_pkg::smfc_q_status_t  status
);
  import smfc_pkg::*;

  smfc_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hdl/smfc_back.sv @@
// ----------------------------------------------------------------------------
// smfc_back: filter update and calibration
// Updates the per-sensor exponential average, maps the level between the dry
// and wet readings with a bit-serial divider and drives the result register.
// ----------------------------------------------------------------------------
module smfc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [smfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smfc_pkg::CAL_W-1:0]     cfg_data,
  input  smfc_pkg::smfc_item_t           head,
  input  smfc_pkg::smfc_q_status_t       status,
  output logic                           pop,
  smfc_out_if.source                     result
);
  import smfc_pkg::*;

  smfc_state_t state, state_next;

  logic [CAL_W-1:0]    calibration [CAL_COUNT];
  logic [LEVEL_W-1:0]  filtered    [SENSOR_COUNT];

  smfc_item_t          cur;
  logic [SAMPLE_W-1:0] level;
  logic                err;
  logic [QUOT_W-1:0]   quot;
  logic [NUM_W-1:0]    rem;
  logic [SAMPLE_W-1:0] den_mag;
  logic [STEP_W-1:0]   step;
  logic                out_valid;
  logic                out_free;
  logic                load_out;

  logic [LEVEL_W-1:0]     old_level;
  logic [LEVEL_W-1:0]     new_part;
  logic [LEVEL_W+5:0]     old_part;
  logic [LEVEL_W-1:0]     new_level;
  logic [SAMPLE_W-1:0]    dry;
  logic [SAMPLE_W-1:0]    wet;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] den;
  logic [SAMPLE_W-1:0]    diff_mag;
  logic [SAMPLE_W-1:0]    den_abs;
  logic [NUM_W-1:0]       num_mag;
  logic                   opposite;
  logic [NUM_W:0]         trial;

  assign out_free = !out_valid || result.ready;

  // Filter update: new = 205*raw + ((51*old + 128) >> 8).
  always_comb begin
    old_level = filtered[cur.idx];
    new_part  = LEVEL_W'(cur.raw) * LEVEL_W'(GAIN_NEW);
    old_part  = (LEVEL_W+6)'(old_level) * (LEVEL_W+6)'(GAIN_OLD) + (LEVEL_W+6)'(ROUND_HALF);
    new_level = new_part + LEVEL_W'(old_part[LEVEL_W+5:FRAC_W]);
  end

  // Calibration setup.
  always_comb begin
    dry      = calibration[cur.idx][CAL_W-1:CAL_HALF_W];
    wet      = calibration[cur.idx][CAL_HALF_W-1:0];
    diff     = $signed({1'b0, level}) - $signed({1'b0, dry});
    den      = $signed({1'b0, wet}) - $signed({1'b0, dry});
    diff_mag = diff[DIFF_W-1] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    den_abs  = den[DIFF_W-1] ? SAMPLE_W'(-den) : den[SAMPLE_W-1:0];
    num_mag  = NUM_W'(diff_mag) * NUM_W'(PCT_MAX);
    opposite = (diff[DIFF_W-1] != den[DIFF_W-1]) && (diff != '0);
    trial    = {1'b0, rem} - ((NUM_W+1)'(den_mag) << step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!status.empty) begin
          pop        = 1'b1;
          state_next = head.bad ? ST_FINISH : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_PREP;
      end
      ST_PREP: begin
        if (dry == wet || opposite || num_mag >= {den_abs, QUOT_W'(0)}) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAL_COUNT; i++) begin
        calibration[i] <= '0;
      end
    end else if (cfg_write && cfg_index < CFG_IDX_W'(CAL_COUNT)) begin
      calibration[cfg_index[CAL_SEL_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        filtered[i] <= '0;
      end
    end else if (state == ST_UPDATE) begin
      filtered[cur.idx] <= new_level;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur   <= head;
        level <= '0;
        err   <= 1'b1;
        quot  <= '0;
      end
      ST_UPDATE: begin
        level <= new_level[LEVEL_W-1:FRAC_W];
      end
      ST_PREP: begin
        err     <= (dry == wet);
        rem     <= num_mag;
        den_mag <= den_abs;
        step    <= STEP_W'(QUOT_W - 1);
        if (dry == wet || opposite) begin
          quot <= '0;
        end else if (num_mag >= {den_abs, QUOT_W'(0)}) begin
          quot <= QUOT_W'(PCT_MAX);
        end else begin
          quot <= '0;
        end
      end
      ST_DIVIDE: begin
        if (!trial[NUM_W]) begin
          rem        <= trial[NUM_W-1:0];
          quot[step] <= 1'b1;
        end
        step <= step - STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.moisture_percent <= (quot > QUOT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : PCT_W'(quot);
      result.smoothed_level   <= level;
      result.error            <= err;
    end
  end

  assign result.valid = out_valid;

endmodule

@@ hdl/soil_moisture_filter_calibrate_unit.sv @@
// ----------------------------------------------------------------------------
// soil_moisture_filter_calibrate_unit: soil moisture filter and calibration
// Smooths each sensor's samples and maps the level to a percentage between
// its dry and wet readings.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  sample    sink       sensor_number, raw_sample
//  result    source     moisture_percent, smoothed_level, error
//  cfg       write      cfg_index, cfg_data (calibration 0 to 7)
//
// A valid sample passes from the queue through the update and setup states
// and the 7-step serial divider to the result register; the divider is
// skipped when the percentage is settled without it (equal readings, opposite
// sign or full scale), and a bad sensor number goes straight to the finish
// state. The intake queue holds two samples, so intake runs ahead while a
// result waits. Reset clears the averages and calibration registers at once.
// ----------------------------------------------------------------------------
module soil_moisture_filter_calibrate_unit (
  input  logic                           clk,
  input  logic                           rst,
  smfc_in_if.sink                        sample,
  smfc_out_if.source                     result,
  input  logic                           cfg_write,
  input  logic [smfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smfc_pkg::CAL_W-1:0]     cfg_data
);
  import smfc_pkg::*;

  smfc_q_status_t status;
  smfc_item_t     push_item;
  smfc_item_t     head;
  logic           push;
  logic           pop;

  smfc_front u_front (
    .sample (sample),
    .status (status),
    .push   (push),
    .item   (push_item)
  );

  smfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  smfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .result    (result)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("sample pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue popped while empty");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.moisture_percent <= PCT_W'(PCT_MAX))
    else $error("moisture percentage above full scale");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error |-> result.moisture_percent == '0)
    else $error("error result with nonzero percentage");

endmodule

@@ tb/soil_moisture_filter_calibrate_unit_test.sv @@
// ----------------------------------------------------------------------------
// soil_moisture_filter_calibrate_unit_test: self-checking bench of the filter
// Writes calibration settings, streams sensor samples with random gaps and
// result back-pressure, and compares every result beat with a model of the
// per-sensor smoothing and the dry-to-wet percentage mapping.
// ----------------------------------------------------------------------------
module soil_moisture_filter_calibrate_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import smfc_pkg::*;

  typedef struct {
    logic [PCT_W-1:0]    percent;
    logic [SAMPLE_W-1:0] level;
    logic                err;
  } reading_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAL_W-1:0]     cfg_data;

  smfc_in_if  sample_ch ();
  smfc_out_if result_ch ();

  soil_moisture_filter_calibrate_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [CAL_W-1:0]   cal_table [CAL_COUNT];
  logic [LEVEL_W-1:0] avg_level [SENSOR_COUNT];
  reading_t           expected_readings [$];
  int unsigned        fail_count = 0;
  int unsigned        stall_left = 0;
  bit                 steady = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic reading_t predict_moisture(input logic [SENSOR_W-1:0] sensor,
                                                input logic [SAMPLE_W-1:0] raw);
    reading_t        r;
    int unsigned     sel;
    longint unsigned acc;
    longint unsigned old_part;
    int              lvl;
    int              dry;
    int              wet;
    int              pct;
    r.percent = '0;
    r.level   = '0;
    r.err     = 1'b1;
    if (sensor == 0 || sensor > SENSOR_COUNT) return r;
    sel      = sensor - 1;
    acc      = 64'(raw);
    acc      = (acc << FRAC_W) * GAIN_NEW;
    old_part = 64'(avg_level[sel]);
    acc      = acc + old_part * GAIN_OLD + ROUND_HALF;
    avg_level[sel] = acc[FRAC_W +: LEVEL_W];
    lvl = int'(avg_level[sel][LEVEL_W-1 -: SAMPLE_W]);
    dry = int'(cal_table[sel][CAL_W-1 -: CAL_HALF_W]);
    wet = int'(cal_table[sel][CAL_HALF_W-1:0]);
    r.level = SAMPLE_W'(lvl);
    if (dry == wet) return r;
    pct = ((lvl - dry) * PCT_MAX) / (wet - dry);
    if (pct < 0) pct = 0;
    if (pct > PCT_MAX) pct = PCT_MAX;
    r.percent = PCT_W'(pct);
    r.err     = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sample(input logic [SENSOR_W-1:0] sensor,
                             input logic [SAMPLE_W-1:0] raw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.sensor_number <= sensor;
    sample_ch.raw_sample    <= raw;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    expected_readings.push_back(predict_moisture(sensor, raw));
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  task automatic write_cal(input int idx, input logic [CAL_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= data;
    @(posedge clk);
    if (idx < CAL_COUNT) cal_table[idx] = data;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_backpressure
    int roll;
    if (steady) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b0;
        stall_left = (roll < 96) ? $urandom_range(0, 3) : $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin : reading_check
    reading_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unrequested beat, smoothed_level", -1, result_ch.smoothed_level);
      end else begin
        want = expected_readings.pop_front();
        if (result_ch.moisture_percent !== want.percent) begin
          report_mismatch("moisture_percent", want.percent, result_ch.moisture_percent);
        end
        if (result_ch.smoothed_level !== want.level) begin
          report_mismatch("smoothed_level", want.level, result_ch.smoothed_level);
        end
        if (result_ch.error !== want.err) begin
          report_mismatch("error", want.err, result_ch.error);
        end
      end
    end
  end

  // With every calibration at zero, dry equals wet on all sensors.
  task automatic test_reset_state();
    for (int s = 0; s <= SENSOR_COUNT + 1; s++) begin
      send_sample(SENSOR_W'(s), 12'hFFF);
    end
    send_sample(4'hF, 12'h000);
    wait_drained();
  endtask

  task automatic test_calibration_extremes();
    write_cal(0, {12'hFFF, 12'h000});
    write_cal(1, {12'h000, 12'hFFF});
    write_cal(2, {12'd2000, 12'd2000});
    write_cal(3, {12'd1000, 12'd1001});
    write_cal(4, {12'hFFF, 12'hFFE});
    write_cal(5, {12'd3000, 12'd1000});
    write_cal(6, 24'hFFFFFF);
    write_cal(7, {12'd100, 12'd3900});
    for (int i = CAL_COUNT; i < (1 << CFG_IDX_W); i++) begin
      write_cal(i, CAL_W'($urandom));
    end
    send_sample(4'd1, 12'h000);
    send_sample(4'd1, 12'hFFF);
    send_sample(4'd2, 12'hFFF);
    send_sample(4'd2, 12'hFFF);
    send_sample(4'd3, 12'd1234);
    send_sample(4'd4, 12'd1001);
    send_sample(4'd4, 12'd1000);
    send_sample(4'd5, 12'hFFF);
    send_sample(4'd5, 12'h000);
    send_sample(4'd6, 12'd2000);
    send_sample(4'd7, 12'hFFF);
    send_sample(4'd8, 12'hFFF);
    send_sample(4'd8, 12'h000);
    send_sample(4'd0, 12'hFFF);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int          target [SENSOR_COUNT];
    int          dry;
    int          wet;
    int          roll;
    int          value;
    logic [SENSOR_W-1:0] sensor;
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      steady = (phase == 2);
      for (int s = 0; s < CAL_COUNT; s++) begin
        case ($urandom_range(0, 5))
          0: begin
            dry = $urandom_range(0, 4095);
            wet = $urandom_range(0, 4095);
          end
          1: begin
            dry = 0;
            wet = 4095;
          end
          2: begin
            dry = 4095;
            wet = 0;
          end
          3: begin
            dry = $urandom_range(0, 4095);
            wet = dry;
          end
          4: begin
            dry = $urandom_range(0, 4000);
            wet = dry + $urandom_range(1, 60);
            if ($urandom_range(0, 1)) begin
              value = dry;
              dry   = wet;
              wet   = value;
            end
          end
          default: begin
            dry = $urandom_range(0, 1500);
            wet = $urandom_range(2500, 4095);
            if ($urandom_range(0, 1)) begin
              value = dry;
              dry   = wet;
              wet   = value;
            end
          end
        endcase
        write_cal(s, {12'(dry), 12'(wet)});
        target[s] = (dry < wet) ? $urandom_range(dry, wet) : $urandom_range(wet, dry);
      end
      write_cal($urandom_range(CAL_COUNT, (1 << CFG_IDX_W) - 1), CAL_W'($urandom));
      for (int n = 0; n < 280; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          sensor = $urandom_range(0, 1) ? 4'd0 : SENSOR_W'($urandom_range(SENSOR_COUNT + 1, 15));
        end else begin
          sensor = SENSOR_W'($urandom_range(1, SENSOR_COUNT));
        end
        roll = $urandom_range(0, 99);
        if (roll < 35 || sensor == 0 || sensor > SENSOR_COUNT) begin
          value = $urandom_range(0, 4095);
        end else if (roll < 80) begin
          value = target[sensor - 1] + $urandom_range(0, 62) - 31;
          if (value < 0) value = 0;
          if (value > 4095) value = 4095;
        end else begin
          value = $urandom_range(0, 1) ? 4095 : 0;
        end
        send_sample(sensor, 12'(value));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < CAL_COUNT; i++) cal_table[i] = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) avg_level[i] = '0;
    rst                     <= 1'b1;
    cfg_write               <= 1'b0;
    cfg_index               <= '0;
    cfg_data                <= '0;
    sample_ch.valid         <= 1'b0;
    sample_ch.sensor_number <= '0;
    sample_ch.raw_sample    <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_calibration_extremes();
    test_random_traffic();
    wait_drained();
    repeat (24) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hdl/smfc_pkg.sv
hdl/smfc_if.sv
hdl/smfc_front.sv
hdl/smfc_queue.sv
hdl/smfc_back.sv
hdl/soil_moisture_filter_calibrate_unit.sv
tb/soil_moisture_filter_calibrate_unit_test.sv
